>>> hw/rtl/cfq_pkg.sv
package cfq_pkg;

  // fixed field widths
  localparam int WordW   = 32;
  localparam int ModeW   = 3;
  localparam int CfgW    = 5;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  // operation codes
  localparam logic [ModeW-1:0] ModeEnq   = 3'd0;
  localparam logic [ModeW-1:0] ModeDeq   = 3'd1;
  localparam logic [ModeW-1:0] ModePeek  = 3'd2;
  localparam logic [ModeW-1:0] ModeClear = 3'd3;
  localparam logic [ModeW-1:0] ModeQuery = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // capacity register after reset
  localparam logic [CfgW-1:0] CapReset = 5'd16;

  // one input transaction
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] data_in;
  } cfq_in_t;

  // one result transaction
  typedef struct packed {
    logic [WordW-1:0]   data_out;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic               is_empty;
  } cfq_res_t;

  // per-cell control from the pointer logic
  typedef struct packed {
    logic wr_en;
    logic rd_sel;
  } cfq_cell_ctl_t;

endpackage

>>> hw/rtl/cfq_cell.sv
module cfq_cell (
  input  logic                      clk_i,
  input  cfq_pkg::cfq_cell_ctl_t    ctl_i,
  input  logic [cfq_pkg::WordW-1:0] wr_data_i,
  input  logic [cfq_pkg::WordW-1:0] chain_i,
  output logic [cfq_pkg::WordW-1:0] chain_o
);

  logic [cfq_pkg::WordW-1:0] slot_q;
  logic [cfq_pkg::WordW-1:0] chain_q;

  // slot storage, written when the tail points here
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      slot_q <= wr_data_i;
    end
  end

  // read chain: take own slot when selected, else pass the neighbor's word on
  always_ff @(posedge clk_i) begin
    chain_q <= ctl_i.rd_sel ? slot_q : chain_i;
  end

  assign chain_o = chain_q;

endmodule

>>> hw/rtl/cfq_ctrl.sv
module cfq_ctrl #(
  parameter int Depth = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfq_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           start,
  output logic                           busy,
  input  cfq_pkg::cfq_in_t               in_i,
  input  logic [cfq_pkg::WordW-1:0]      chain_last_i,
  output logic                           wr_en_o,
  output logic [$clog2(Depth)-1:0]       wr_idx_o,
  output logic [$clog2(Depth)-1:0]       rd_idx_o,
  output logic                           done_o,
  output cfq_pkg::cfq_res_t              res_o
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int CmpW = (CntW > cfq_pkg::CfgW) ? CntW : cfq_pkg::CfgW;

  logic [cfq_pkg::CfgW-1:0] cap_q;
  logic [IdxW-1:0]          head_q, head_d;
  logic [IdxW-1:0]          tail_q, tail_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [IdxW-1:0]          rd_idx_q;
  logic [CntW-1:0]          wait_q;
  logic                     busy_q;
  logic                     done_q;
  cfq_pkg::cfq_res_t        res_q;

  logic                      accept;
  logic                      rd_go;
  logic                      full;
  logic                      empty;
  logic [CmpW-1:0]           eff_cap;
  logic [cfq_pkg::StatusW-1:0] status;
  logic                      finish;

  // index step with wrap at the effective capacity or the store end
  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] idx,
                                              input logic [CmpW-1:0] cap);
    logic [CmpW-1:0] nxt;
    nxt = CmpW'(idx) + CmpW'(1);
    if (nxt >= cap || nxt >= CmpW'(Depth)) begin
      return '0;
    end
    return IdxW'(nxt);
  endfunction

  // capacity clamped to one .. depth
  always_comb begin
    eff_cap = CmpW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(Depth)) begin
      eff_cap = CmpW'(Depth);
    end
  end

  assign accept = start & ~busy_q;
  assign full   = CmpW'(fill_q) >= eff_cap;
  assign empty  = fill_q == '0;
  assign finish = busy_q && (wait_q == CntW'(Depth));

  // operation decode and pointer update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    wr_en_o = 1'b0;
    rd_go   = 1'b0;
    status  = cfq_pkg::StatusOk;
    if (accept) begin
      unique case (in_i.mode)
        cfq_pkg::ModeEnq: begin
          if (full) begin
            status = cfq_pkg::StatusFull;
          end else begin
            wr_en_o = 1'b1;
            tail_d  = advance(tail_q, eff_cap);
            fill_d  = fill_q + CntW'(1);
          end
        end
        cfq_pkg::ModeDeq: begin
          if (empty) begin
            status = cfq_pkg::StatusEmpty;
          end else begin
            rd_go  = 1'b1;
            head_d = advance(head_q, eff_cap);
            fill_d = fill_q - CntW'(1);
          end
        end
        cfq_pkg::ModePeek: begin
          if (empty) begin
            status = cfq_pkg::StatusEmpty;
          end else begin
            rd_go = 1'b1;
          end
        end
        cfq_pkg::ModeClear: begin
          head_d = '0;
          tail_d = '0;
          fill_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cfq_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // read wait: the word ripples down the cell chain while busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      wait_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (accept) begin
        if (rd_go) begin
          busy_q <= 1'b1;
          wait_q <= '0;
        end else begin
          done_q <= 1'b1;
        end
      end else if (finish) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        wait_q <= wait_q + CntW'(1);
      end
    end
  end

  // result register; read data lands when the chain has settled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_idx_q       <= head_q;
      res_q.data_out <= '0;
      res_q.status   <= status;
      res_q.count    <= cfq_pkg::CountW'(fill_d);
      res_q.is_empty <= fill_d == '0;
    end else if (finish) begin
      res_q.data_out <= chain_last_i;
    end
  end

  assign wr_idx_o = tail_q;
  assign rd_idx_o = rd_idx_q;
  assign busy     = busy_q;
  assign done_o   = done_q;
  assign res_o    = res_q;

endmodule

>>> hw/rtl/circular_fifo_queue.sv
// Ring-buffer FIFO with one result transaction per input transaction. An
// operation is taken at a clock edge where start is high and busy is low.
// Enqueue, clear, query and any dequeue or peek on an empty queue answer with
// done_o high in the next cycle, and busy stays low, so these run at one
// operation per cycle. A dequeue or peek that reads a word raises busy until
// it answers, while the head word travels one cell per cycle down the row of
// Depth storage cells. The result is shown for exactly one cycle; the receiver
// cannot stall it and must take it when done_o is high. Capacity is written
// through cfg_we_i; the user must write it only while the block is idle, and
// the block itself does not enforce this.
module circular_fifo_queue #(
  parameter int Depth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfq_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  cfq_pkg::cfq_in_t              in_i,
  output logic                          done_o,
  output cfq_pkg::cfq_res_t             res_o
);

  localparam int IdxW = $clog2(Depth);

  logic                      wr_en;
  logic [IdxW-1:0]           wr_idx;
  logic [IdxW-1:0]           rd_idx;
  logic [cfq_pkg::WordW-1:0] chain [Depth+1];

  // pointer, count and result control
  cfq_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .chain_last_i(chain[Depth]),
    .wr_en_o     (wr_en),
    .wr_idx_o    (wr_idx),
    .rd_idx_o    (rd_idx),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  assign chain[0] = '0;

  // row of storage cells with the read chain running through them
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cfq_pkg::cfq_cell_ctl_t ctl;

    assign ctl.wr_en  = wr_en && (wr_idx == IdxW'(i));
    assign ctl.rd_sel = rd_idx == IdxW'(i);

    cfq_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .wr_data_i(in_i.data_in),
      .chain_i  (chain[i]),
      .chain_o  (chain[i+1])
    );
  end

endmodule
